[rtl/core/mt19937_random_generator_macros.svh]
// Assertion helpers for the MT19937 generator.
`ifndef MT19937_RANDOM_GENERATOR_MACROS_SVH
`define MT19937_RANDOM_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define MTRG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mtrg: same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define MTRG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mtrg: next-cycle check failed");

`endif

[rtl/core/mtrg_pkg.sv]
`default_nettype none

package mtrg_pkg;

    localparam int STATE_WORDS_DEF  = 624;
    localparam int SHIFT_OFFSET_DEF = 397;

    typedef logic [31:0] word_t;

    localparam word_t SEED_MULT    = 32'd69069;
    localparam word_t AUTO_SEED    = 32'd4357;
    localparam word_t TWIST_MATRIX = 32'h9908_b0df;
    localparam word_t TEMPER_B     = 32'h9d2c_5680;
    localparam word_t TEMPER_C     = 32'hefc6_0000;
    localparam word_t HIGH_BIT     = 32'h8000_0000;
    localparam word_t LOW_BITS     = 32'h7fff_ffff;

    // request opcodes
    localparam logic CMD_GENERATE = 1'b0;
    localparam logic CMD_RESEED   = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic fill_load;   // start seeding, ptr <= 0
        logic fill_auto;   // seed with AUTO_SEED instead of request seed
        logic fill_step;   // write one seeded word
        logic tw_pre;      // fetch word 0, ptr <= 0
        logic tw_read;     // fetch next and far words
        logic tw_write;    // write twisted word
        logic gen_read;    // fetch word at read index
        logic out_load;    // temper into output register
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic ptr_last;
        logic unseeded;
        logic twist_due;
    } dp_status_t;

    function automatic word_t temper(input word_t y);
        word_t t;
        t = y ^ (y >> 11);
        t = t ^ ((t << 7) & TEMPER_B);
        t = t ^ ((t << 15) & TEMPER_C);
        t = t ^ (t >> 18);
        return t;
    endfunction

endpackage

`default_nettype wire

[rtl/core/mtrg_req_if.sv]
`default_nettype none

interface mtrg_req_if;
    import mtrg_pkg::*;

    logic  valid;
    logic  ready;
    logic  cmd;
    word_t seed;

    modport source (output valid, output cmd, output seed, input ready);
    modport sink   (input valid, input cmd, input seed, output ready);
endinterface

`default_nettype wire

[rtl/core/mtrg_rsp_if.sv]
`default_nettype none

interface mtrg_rsp_if;
    import mtrg_pkg::*;

    logic  valid;
    logic  ready;
    word_t random_word;

    modport source (output valid, output random_word, input ready);
    modport sink   (input valid, input random_word, output ready);
endinterface

`default_nettype wire

[rtl/core/mtrg_controller.sv]
`default_nettype none

module mtrg_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_cmd,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output mtrg_pkg::dp_cmd_t    ctrl,
    input  mtrg_pkg::dp_status_t status
);
    import mtrg_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_FILL     = 3'd1;
    localparam logic [2:0] ST_TW_PRE   = 3'd2;
    localparam logic [2:0] ST_TW_READ  = 3'd3;
    localparam logic [2:0] ST_TW_WRITE = 3'd4;
    localparam logic [2:0] ST_GEN_READ = 3'd5;
    localparam logic [2:0] ST_GEN_OUT  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       pending_reg;   // a generate waits behind an auto-seed fill
    logic       pending_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;
    logic       out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        pending_next = pending_reg;
        ctrl         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_cmd == CMD_RESEED)
                    begin
                        ctrl.fill_load = 1'b1;
                        pending_next   = 1'b0;
                        state_next     = ST_FILL;
                    end
                    else if (status.unseeded)
                    begin
                        ctrl.fill_load = 1'b1;
                        ctrl.fill_auto = 1'b1;
                        pending_next   = 1'b1;
                        state_next     = ST_FILL;
                    end
                    else if (status.twist_due)
                    begin
                        state_next = ST_TW_PRE;
                    end
                    else
                    begin
                        state_next = ST_GEN_READ;
                    end
                end
            end
            ST_FILL:
            begin
                ctrl.fill_step = 1'b1;
                if (status.ptr_last)
                begin
                    state_next = pending_reg ? ST_TW_PRE : ST_IDLE;
                end
            end
            ST_TW_PRE:
            begin
                ctrl.tw_pre = 1'b1;
                state_next  = ST_TW_READ;
            end
            ST_TW_READ:
            begin
                ctrl.tw_read = 1'b1;
                state_next   = ST_TW_WRITE;
            end
            ST_TW_WRITE:
            begin
                ctrl.tw_write = 1'b1;
                state_next    = status.ptr_last ? ST_GEN_READ : ST_TW_READ;
            end
            ST_GEN_READ:
            begin
                ctrl.gen_read = 1'b1;
                state_next    = ST_GEN_OUT;
            end
            ST_GEN_OUT:
            begin
                if (out_free)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (ctrl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/mtrg_datapath.sv]
`default_nettype none

module mtrg_datapath #(
    parameter int STATE_WORDS  = mtrg_pkg::STATE_WORDS_DEF,
    parameter int SHIFT_OFFSET = mtrg_pkg::SHIFT_OFFSET_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mtrg_pkg::dp_cmd_t    ctrl,
    input  mtrg_pkg::word_t      seed,
    output mtrg_pkg::dp_status_t status,
    output mtrg_pkg::word_t      random_word
);
    import mtrg_pkg::*;

    localparam int ADDR_W = $clog2(STATE_WORDS);
    localparam int IDX_W  = $clog2(STATE_WORDS + 2);

    localparam logic [ADDR_W-1:0] LAST_ADDR    = ADDR_W'(STATE_WORDS - 1);
    localparam logic [IDX_W-1:0]  IDX_TWIST    = IDX_W'(STATE_WORDS);
    localparam logic [IDX_W-1:0]  IDX_UNSEEDED = IDX_W'(STATE_WORDS + 1);

    word_t mem [STATE_WORDS];

    logic [ADDR_W-1:0] ptr_reg;
    logic [ADDR_W-1:0] ptr_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;

    word_t fill_val_reg;
    word_t cur_reg;      // old word[k], taken from the previous fetch
    word_t rd_a_reg;
    word_t rd_b_reg;
    word_t out_reg;

    logic [ADDR_W-1:0] nxt_addr;
    logic [ADDR_W:0]   far_sum;
    logic [ADDR_W-1:0] far_addr;
    logic [ADDR_W-1:0] rd_a_addr;
    logic              rd_a_en;
    logic              wr_en;
    word_t             wr_data;
    word_t             mix;
    word_t             twisted;

    assign nxt_addr = (ptr_reg == LAST_ADDR) ? '0 : ptr_reg + 1'b1;
    assign far_sum  = {1'b0, ptr_reg} + (ADDR_W + 1)'(SHIFT_OFFSET);
    assign far_addr = (far_sum >= (ADDR_W + 1)'(STATE_WORDS))
                    ? ADDR_W'(far_sum - (ADDR_W + 1)'(STATE_WORDS))
                    : ADDR_W'(far_sum);

    always_comb
    begin
        priority if (ctrl.gen_read)
        begin
            rd_a_addr = ADDR_W'(idx_reg);
        end
        else if (ctrl.tw_read)
        begin
            rd_a_addr = nxt_addr;
        end
        else
        begin
            rd_a_addr = '0;
        end
    end
    assign rd_a_en = ctrl.gen_read | ctrl.tw_read | ctrl.tw_pre;

    assign mix     = (cur_reg & HIGH_BIT) | (rd_a_reg & LOW_BITS);
    assign twisted = rd_b_reg ^ (mix >> 1) ^ (mix[0] ? TWIST_MATRIX : '0);

    assign wr_en   = ctrl.fill_step | ctrl.tw_write;
    assign wr_data = ctrl.fill_step ? fill_val_reg : twisted;

    // store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[ptr_reg] <= wr_data;
        end
        if (rd_a_en)
        begin
            rd_a_reg <= mem[rd_a_addr];
        end
        if (ctrl.tw_read)
        begin
            rd_b_reg <= mem[far_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.tw_read)
        begin
            cur_reg <= rd_a_reg;
        end
        if (ctrl.fill_load)
        begin
            fill_val_reg <= ctrl.fill_auto ? AUTO_SEED : seed;
        end
        else if (ctrl.fill_step)
        begin
            fill_val_reg <= fill_val_reg * SEED_MULT;
        end
        if (ctrl.out_load)
        begin
            out_reg <= temper(rd_a_reg);
        end
    end

    always_comb
    begin
        ptr_next = ptr_reg;
        if (ctrl.fill_load || ctrl.tw_pre)
        begin
            ptr_next = '0;
        end
        else if ((ctrl.fill_step || ctrl.tw_write) && (ptr_reg != LAST_ADDR))
        begin
            ptr_next = ptr_reg + 1'b1;
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (ctrl.fill_step && (ptr_reg == LAST_ADDR))
        begin
            idx_next = IDX_TWIST;
        end
        else if (ctrl.tw_write && (ptr_reg == LAST_ADDR))
        begin
            idx_next = '0;
        end
        else if (ctrl.out_load)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
            idx_reg <= IDX_UNSEEDED;
        end
        else
        begin
            ptr_reg <= ptr_next;
            idx_reg <= idx_next;
        end
    end

    assign status.ptr_last  = (ptr_reg == LAST_ADDR);
    assign status.unseeded  = (idx_reg == IDX_UNSEEDED);
    assign status.twist_due = (idx_reg == IDX_TWIST);
    assign random_word      = out_reg;

endmodule

`default_nettype wire

[rtl/core/mt19937_random_generator.sv]
// MT19937 32-bit Mersenne Twister. A request item carries cmd and seed: cmd reseed fills
// the 624-word store from seed (word 0 = seed, each next word = 69069 * previous) and
// returns nothing; cmd generate returns one tempered word on the result channel.
// A reseed holds request.ready low while the store is filled, one store write per cycle.
// A generate holds request.ready low through the store read and then the temper of the
// registered read data into the output register, which waits while the previous word is
// untaken, so a new generate is taken only after the last word has been loaded.
// Every 624 words the whole store is twisted in place first: word 0 is fetched, then
// each word needs a fetch step (next and far words on two read ports) and a write step.
// A generate before any reseed seeds with 4357 and then twists.
// The result register holds a word until taken; the next request is accepted meanwhile,
// and a generate waits only if the previous word is still untaken when its own is ready.
// Store contents are not reset; they are always written before being read.
`default_nettype none

module mt19937_random_generator #(
    parameter int STATE_WORDS  = mtrg_pkg::STATE_WORDS_DEF,
    parameter int SHIFT_OFFSET = mtrg_pkg::SHIFT_OFFSET_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    mtrg_req_if.sink   request,
    mtrg_rsp_if.source result
);
    import mtrg_pkg::*;

    dp_cmd_t    ctrl;
    dp_status_t status;
    word_t      word_out;
    logic       out_valid;

    // sequencing: seed fill, twist sweep, read/temper
    mtrg_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_cmd    (request.cmd),
        .in_ready  (request.ready),
        .out_valid (out_valid),
        .out_ready (result.ready),
        .ctrl      (ctrl),
        .status    (status)
    );

    // store, seeding multiplier, twist and temper logic, output register
    mtrg_datapath #(
        .STATE_WORDS  (STATE_WORDS),
        .SHIFT_OFFSET (SHIFT_OFFSET)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .seed        (request.seed),
        .status      (status),
        .random_word (word_out)
    );

    assign result.valid       = out_valid;
    assign result.random_word = word_out;

endmodule

`default_nettype wire

[rtl/core/mtrg_checker.sv]
`default_nettype none
`include "mt19937_random_generator_macros.svh"

module mtrg_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            req_valid,
    input logic            req_ready,
    input logic            req_cmd,
    input logic            rsp_valid,
    input logic            rsp_ready,
    input mtrg_pkg::word_t rsp_word
);
    import mtrg_pkg::*;

    // a word on offer stays until taken
    `MTRG_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)
    `MTRG_ASSERT_NEXT(a_rsp_stable, clk, rst_n, rsp_valid && !rsp_ready, $stable(rsp_word))

    // a reseed keeps the block busy filling the store
    `MTRG_ASSERT_NEXT(a_reseed_busy, clk, rst_n,
        req_valid && req_ready && (req_cmd == CMD_RESEED), !req_ready)

    // no word appears in the cycle right after a request is taken
    `MTRG_ASSERT_NEXT(a_no_instant_word, clk, rst_n,
        req_valid && req_ready && !rsp_valid, !rsp_valid)

endmodule

bind mt19937_random_generator mtrg_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .req_cmd   (request.cmd),
    .rsp_valid (result.valid),
    .rsp_ready (result.ready),
    .rsp_word  (result.random_word)
);

`default_nettype wire
